@@ rtl/clc_pkg.sv @@
// Shared constants and types for the circular linked list cursor.
package clc_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    KIND_NEXT   = 3'd0,
    KIND_PREV   = 3'd1,
    KIND_INS_AF = 3'd2,
    KIND_INS_BF = 3'd3,
    KIND_REMOVE = 3'd4,
    KIND_READ   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_STEP_BACK,
    S_INS_POP,
    S_INS_LINK,
    S_RM_READ
  } state_e;

endpackage

@@ rtl/circular_linked_list_cursor.sv @@
// Circular doubly linked list with cursor, node pool held in link memories.
//
//  channel   ports                                   beat taken when
//  -------   -------------------------------------   -------------------------
//  command   start_i, busy_o, kind_i, value_i        start_i & ~busy_o at clk
//  result    done_o, status_o, data_o, is_empty_o    done_o high, one cycle
//
// Read, next, prev or remove on an empty list, and insert after on a full pool,
// give their result one cycle after the command and never raise busy.
// Next/prev read one node (S_LOAD); insert after pops a node (S_INS_POP), then
// links it on a non-empty list (S_INS_LINK); insert before first steps back on
// a non-empty list (S_STEP_BACK, ending there on a full pool); remove of a node
// other than the last writes the relink, then reads a node (S_RM_READ, S_LOAD).
// These steps follow from the single read and write port of each link memory.
// Reset empties the list and marks the whole free stack as holding i at i.
// Results cannot be stalled; a new command may be taken in the result cycle.
module circular_linked_list_cursor
  import clc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [2:0]               kind_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic                     is_empty_o
);

  // node memories and free stack
  logic [DATA_W-1:0] node_value [CAPACITY];
  idx_t              next_link  [CAPACITY];
  idx_t              prev_link  [CAPACITY];
  idx_t              free_stack [CAPACITY];
  logic [CAPACITY-1:0] fs_valid_q;

  state_e state_q, state_d;

  idx_t              cursor_q, cursor_d;
  logic              nonempty_q, nonempty_d;
  cnt_t              free_cnt_q, free_cnt_d;
  logic [DATA_W-1:0] cur_val_q, cur_val_d;
  idx_t              cur_next_q, cur_next_d;
  idx_t              cur_prev_q, cur_prev_d;
  kind_e             op_q, op_d;
  logic [DATA_W-1:0] ins_val_q, ins_val_d;
  idx_t              new_idx_q, new_idx_d;

  // read ports
  idx_t              node_raddr;
  logic [DATA_W-1:0] nv_rd_q;
  idx_t              nx_rd_q, pv_rd_q;
  idx_t              fs_raddr;
  idx_t              fs_rd_q, fs_ridx_q;
  logic              fs_rvalid_q;

  // write ports
  logic              nv_we, nx_we, pv_we, fs_we;
  idx_t              nv_waddr, nx_waddr, pv_waddr, fs_waddr;
  logic [DATA_W-1:0] nv_wdata;
  idx_t              nx_wdata, pv_wdata, fs_wdata;

  // result registers
  logic                     done_q, done_d;
  logic [1:0]               status_q, status_d;
  logic [DATA_W-1:0]        data_q, data_d;
  logic                     empty_q;

  logic  accept;
  kind_e kind;
  idx_t  popped;
  cnt_t  free_dec;

  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q != S_IDLE);
  assign free_dec = free_cnt_q - cnt_t'(1);
  assign popped   = fs_rvalid_q ? fs_rd_q : fs_ridx_q;

  always_comb begin
    unique case (kind_i)
      KIND_NEXT:   kind = KIND_NEXT;
      KIND_PREV:   kind = KIND_PREV;
      KIND_INS_AF: kind = KIND_INS_AF;
      KIND_INS_BF: kind = KIND_INS_BF;
      KIND_REMOVE: kind = KIND_REMOVE;
      default:     kind = KIND_READ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (kind)
            KIND_NEXT, KIND_PREV: begin
              if (nonempty_q) state_d = S_LOAD;
            end
            KIND_INS_AF: begin
              if (free_cnt_q != '0) state_d = S_INS_POP;
            end
            KIND_INS_BF: begin
              if (nonempty_q) state_d = S_STEP_BACK;
              else if (free_cnt_q != '0) state_d = S_INS_POP;
            end
            KIND_REMOVE: begin
              if (nonempty_q && (cur_next_q != cursor_q)) state_d = S_RM_READ;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_STEP_BACK: state_d = (free_cnt_q != '0) ? S_INS_POP : S_IDLE;
      S_INS_POP:   state_d = nonempty_q ? S_INS_LINK : S_IDLE;
      S_INS_LINK:  state_d = S_IDLE;
      S_RM_READ:   state_d = S_LOAD;
      S_LOAD:      state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cursor_d   = cursor_q;
    nonempty_d = nonempty_q;
    free_cnt_d = free_cnt_q;
    cur_val_d  = cur_val_q;
    cur_next_d = cur_next_q;
    cur_prev_d = cur_prev_q;
    op_d       = op_q;
    ins_val_d  = ins_val_q;
    new_idx_d  = new_idx_q;

    node_raddr = cursor_q;
    fs_raddr   = free_dec[IDX_W-1:0];

    nv_we = 1'b0; nv_waddr = new_idx_q; nv_wdata = ins_val_q;
    nx_we = 1'b0; nx_waddr = new_idx_q; nx_wdata = cur_next_q;
    pv_we = 1'b0; pv_waddr = new_idx_q; pv_wdata = cursor_q;
    fs_we = 1'b0; fs_waddr = free_cnt_q[IDX_W-1:0]; fs_wdata = cursor_q;

    done_d   = 1'b0;
    status_d = ST_OK;
    data_d   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d      = kind;
          ins_val_d = value_i;
          unique case (kind)
            KIND_NEXT, KIND_PREV: begin
              if (nonempty_q) begin
                cursor_d   = (kind == KIND_NEXT) ? cur_next_q : cur_prev_q;
                node_raddr = cursor_d;
              end else begin
                done_d   = 1'b1;
                status_d = ST_EMPTY;
              end
            end
            KIND_INS_AF: begin
              if (free_cnt_q == '0) begin
                done_d   = 1'b1;
                status_d = ST_FULL;
              end
            end
            KIND_INS_BF: begin
              if (nonempty_q) begin
                cursor_d   = cur_prev_q;
                node_raddr = cur_prev_q;
              end else if (free_cnt_q == '0) begin
                done_d   = 1'b1;
                status_d = ST_FULL;
              end
            end
            KIND_REMOVE: begin
              if (nonempty_q) begin
                if (free_cnt_q < cnt_t'(CAPACITY)) begin
                  fs_we      = 1'b1;
                  free_cnt_d = free_cnt_q + cnt_t'(1);
                end
                if (cur_next_q == cursor_q) begin
                  nonempty_d = 1'b0;
                  cursor_d   = '0;
                  done_d     = 1'b1;
                  data_d     = cur_val_q;
                end else begin
                  // unlink; the new cursor node is read once the writes land
                  nx_we    = 1'b1;
                  nx_waddr = cur_prev_q;
                  nx_wdata = cur_next_q;
                  pv_we    = 1'b1;
                  pv_waddr = cur_next_q;
                  pv_wdata = cur_prev_q;
                  cursor_d = cur_next_q;
                  ins_val_d = cur_val_q;
                end
              end else begin
                done_d   = 1'b1;
                status_d = ST_EMPTY;
              end
            end
            default: begin
              done_d = 1'b1;
              if (nonempty_q) data_d = cur_val_q;
              else status_d = ST_EMPTY;
            end
          endcase
        end
      end
      S_STEP_BACK: begin
        cur_val_d  = nv_rd_q;
        cur_next_d = nx_rd_q;
        cur_prev_d = pv_rd_q;
        if (free_cnt_q == '0) begin
          done_d   = 1'b1;
          status_d = ST_FULL;
        end
      end
      S_INS_POP: begin
        free_cnt_d = free_dec;
        new_idx_d  = popped;
        nv_we      = 1'b1;
        nv_waddr   = popped;
        nx_we      = 1'b1;
        nx_waddr   = popped;
        pv_we      = 1'b1;
        pv_waddr   = popped;
        if (!nonempty_q) begin
          nx_wdata   = popped;
          pv_wdata   = popped;
          cursor_d   = popped;
          nonempty_d = 1'b1;
          cur_val_d  = ins_val_q;
          cur_next_d = popped;
          cur_prev_d = popped;
          done_d     = 1'b1;
          data_d     = ins_val_q;
        end
      end
      S_INS_LINK: begin
        nx_we      = 1'b1;
        nx_waddr   = cursor_q;
        nx_wdata   = new_idx_q;
        pv_we      = 1'b1;
        pv_waddr   = cur_next_q;
        pv_wdata   = new_idx_q;
        cur_next_d = new_idx_q;
        if (cur_next_q == cursor_q) cur_prev_d = new_idx_q;
        done_d     = 1'b1;
        data_d     = cur_val_q;
      end
      S_RM_READ: begin
        node_raddr = cursor_q;
      end
      S_LOAD: begin
        cur_val_d  = nv_rd_q;
        cur_next_d = nx_rd_q;
        cur_prev_d = pv_rd_q;
        done_d     = 1'b1;
        data_d     = (op_q == KIND_REMOVE) ? ins_val_q : nv_rd_q;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cursor_q   <= '0;
      nonempty_q <= 1'b0;
      free_cnt_q <= cnt_t'(CAPACITY);
      fs_valid_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cursor_q   <= cursor_d;
      nonempty_q <= nonempty_d;
      free_cnt_q <= free_cnt_d;
      done_q     <= done_d;
      if (fs_we) fs_valid_q[fs_waddr] <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cur_val_q  <= cur_val_d;
    cur_next_q <= cur_next_d;
    cur_prev_q <= cur_prev_d;
    op_q       <= op_d;
    ins_val_q  <= ins_val_d;
    new_idx_q  <= new_idx_d;
    status_q   <= status_d;
    data_q     <= data_d;
    empty_q    <= !nonempty_d;
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (nv_we) node_value[nv_waddr] <= nv_wdata;
    if (nx_we) next_link[nx_waddr]  <= nx_wdata;
    if (pv_we) prev_link[pv_waddr]  <= pv_wdata;
    if (fs_we) free_stack[fs_waddr] <= fs_wdata;
    nv_rd_q   <= node_value[node_raddr];
    nx_rd_q   <= next_link[node_raddr];
    pv_rd_q   <= prev_link[node_raddr];
    fs_rd_q   <= free_stack[fs_raddr];
    fs_ridx_q <= fs_raddr;
  end

  // an unwritten free stack entry holds its own index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fs_rvalid_q <= 1'b0;
    else         fs_rvalid_q <= fs_valid_q[fs_raddr];
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign data_o     = data_q;
  assign is_empty_o = empty_q;

endmodule
